[sv/tbc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centroid block package
// Shared widths, register codes, reset values and the back-end state type.
// ----------------------------------------------------------------------------
package tbc_pkg;

	localparam int PIX_W      = 8;
	localparam int COORD_W    = 12;
	localparam int CFG_DIM_W  = 12;
	localparam int THR_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_DIM_W-1:0] WIDTH_RST     = 12'd640;
	localparam logic [CFG_DIM_W-1:0] HEIGHT_RST    = 12'd480;
	localparam logic [THR_W-1:0]     THRESHOLD_RST = 8'd200;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH      = 2'd0,
		REG_FRAME_HEIGHT     = 2'd1,
		REG_BRIGHT_THRESHOLD = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIFF,
		BK_ABS,
		BK_DIV,
		BK_DONE
	} back_state_t;

endpackage

[sv/tbc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame record queue
// Small register queue that decouples the pixel front end from the divider.
// ----------------------------------------------------------------------------
module tbc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[sv/tbc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel front end
// Tracks raster position, thresholds pixels and gathers the first moments.
// ----------------------------------------------------------------------------
module tbc_front
	import tbc_pkg::*;
#(
	parameter int MAX_DIM = 2048
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [PIX_W-1:0]        pixel_value,
	input  logic [$clog2(MAX_DIM+1)-1:0] frame_w,
	input  logic [$clog2(MAX_DIM+1)-1:0] frame_h,
	input  logic [THR_W-1:0]        threshold,
	input  logic                    q_full,
	output logic                    push,
	output logic [2*($clog2(MAX_DIM*MAX_DIM+1)+$clog2(MAX_DIM))
		+ $clog2(MAX_DIM*MAX_DIM+1) + 2*$clog2(MAX_DIM+1)-1:0] rec_data
);

	localparam int POS_W = $clog2(MAX_DIM);
	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int CNT_W = $clog2(MAX_DIM * MAX_DIM + 1);
	localparam int SUM_W = CNT_W + POS_W;
	localparam int CW    = DIM_W + 1;

	logic [POS_W-1:0] col_q;
	logic [POS_W-1:0] row_q;
	logic [SUM_W-1:0] csum_q;
	logic [SUM_W-1:0] rsum_q;
	logic [CNT_W-1:0] cnt_q;

	logic             accept;
	logic             bright;
	logic [SUM_W-1:0] csum_n;
	logic [SUM_W-1:0] rsum_n;
	logic [CNT_W-1:0] cnt_n;
	logic [CW-1:0]    col_inc;
	logic [CW-1:0]    row_inc;
	logic             row_end;
	logic             frame_end;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;
	assign bright   = (pixel_value > threshold);

	assign csum_n = csum_q + (bright ? SUM_W'(col_q) : '0);
	assign rsum_n = rsum_q + (bright ? SUM_W'(row_q) : '0);
	assign cnt_n  = cnt_q + CNT_W'(bright);

	// A position at or past the last column or row ends the row or frame, so a size
	// change in the middle of a frame still terminates cleanly.
	assign col_inc   = CW'(col_q) + CW'(1);
	assign row_inc   = CW'(row_q) + CW'(1);
	assign row_end   = !(col_inc < CW'(frame_w));
	assign frame_end = row_end && !(row_inc < CW'(frame_h));

	assign push     = accept && frame_end;
	assign rec_data = {csum_n, rsum_n, cnt_n, frame_w, frame_h};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			csum_q <= '0;
			rsum_q <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : POS_W'(row_inc);
			end else begin
				col_q <= POS_W'(col_inc);
			end
			if (frame_end) begin
				csum_q <= '0;
				rsum_q <= '0;
				cnt_q  <= '0;
			end else begin
				csum_q <= csum_n;
				rsum_q <= rsum_n;
				cnt_q  <= cnt_n;
			end
		end
	end

endmodule

[sv/tbc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centroid back end
// Turns one frame record into centered coordinates with a shift-subtract divider.
// ----------------------------------------------------------------------------
module tbc_back
	import tbc_pkg::*;
#(
	parameter int MAX_DIM = 2048
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  logic [2*($clog2(MAX_DIM*MAX_DIM+1)+$clog2(MAX_DIM))
		+ $clog2(MAX_DIM*MAX_DIM+1) + 2*$clog2(MAX_DIM+1)-1:0] rec_data,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [COORD_W-1:0]  center_x,
	output logic [COORD_W-1:0]  center_y,
	output logic                no_points
);

	localparam int POS_W  = $clog2(MAX_DIM);
	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int CNT_W  = $clog2(MAX_DIM * MAX_DIM + 1);
	localparam int SUM_W  = CNT_W + POS_W;
	localparam int PW     = CNT_W + DIM_W;
	localparam int NUM_W  = SUM_W + 2;
	localparam int MAG_W  = NUM_W - 1;
	localparam int QB     = POS_W;
	localparam int STEP_W = (QB > 1) ? $clog2(QB) : 1;
	localparam int RES_W  = (QB + 1 > COORD_W) ? QB + 1 : COORD_W;

	back_state_t state_q;
	back_state_t state_d;

	logic [SUM_W-1:0]  csum_q;
	logic [SUM_W-1:0]  rsum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIM_W-1:0]  w_q;
	logic [DIM_W-1:0]  h_q;
	logic [PW-1:0]     pw_q;
	logic [PW-1:0]     ph_q;
	logic              zero_q;
	logic [NUM_W-1:0]  nx_q;
	logic [NUM_W-1:0]  ny_q;
	logic              neg_x_q;
	logic              neg_y_q;
	logic [MAG_W-1:0]  remx_q;
	logic [MAG_W-1:0]  remy_q;
	logic [MAG_W-1:0]  dsh_q;
	logic [QB-1:0]     qx_q;
	logic [QB-1:0]     qy_q;
	logic [STEP_W-1:0] step_q;

	logic              out_valid_q;
	logic [COORD_W-1:0] cx_q;
	logic [COORD_W-1:0] cy_q;
	logic              np_q;

	logic              load_out;
	logic              ge_x;
	logic              ge_y;
	logic [RES_W-1:0]  sx;
	logic [RES_W-1:0]  sy;

	assign ge_x = (remx_q >= dsh_q);
	assign ge_y = (remy_q >= dsh_q);
	assign sx   = neg_x_q ? -RES_W'(qx_q) : RES_W'(qx_q);
	assign sy   = neg_y_q ? -RES_W'(qy_q) : RES_W'(qy_q);

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					pop     = 1'b1;
					state_d = BK_MUL;
				end
			end
			BK_MUL:  state_d = BK_DIFF;
			BK_DIFF: state_d = BK_ABS;
			BK_ABS:  state_d = BK_DIV;
			BK_DIV: begin
				if (step_q == '0) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Numerators are 2*sum - n*size for x and n*size - 2*sum for y in signed form; the
	// quotient by 2n is taken on magnitudes and the sign put back, which truncates toward zero.
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				{csum_q, rsum_q, cnt_q, w_q, h_q} <= rec_data;
			end
			BK_MUL: begin
				pw_q   <= PW'(cnt_q) * PW'(w_q);
				ph_q   <= PW'(cnt_q) * PW'(h_q);
				zero_q <= (cnt_q == '0);
			end
			BK_DIFF: begin
				nx_q <= {1'b0, csum_q, 1'b0} - NUM_W'(pw_q);
				ny_q <= NUM_W'(ph_q) - {1'b0, rsum_q, 1'b0};
			end
			BK_ABS: begin
				neg_x_q <= nx_q[NUM_W-1];
				neg_y_q <= ny_q[NUM_W-1];
				remx_q  <= MAG_W'(nx_q[NUM_W-1] ? -nx_q : nx_q);
				remy_q  <= MAG_W'(ny_q[NUM_W-1] ? -ny_q : ny_q);
				dsh_q   <= MAG_W'({cnt_q, 1'b0}) << (QB - 1);
				qx_q    <= '0;
				qy_q    <= '0;
				step_q  <= STEP_W'(QB - 1);
			end
			BK_DIV: begin
				if (ge_x) begin
					remx_q <= remx_q - dsh_q;
				end
				if (ge_y) begin
					remy_q <= remy_q - dsh_q;
				end
				qx_q   <= QB'({qx_q, ge_x});
				qy_q   <= QB'({qy_q, ge_y});
				dsh_q  <= dsh_q >> 1;
				step_q <= step_q - STEP_W'(1);
			end
			default: begin
			end
		endcase
		if (load_out) begin
			cx_q <= zero_q ? '0 : sx[COORD_W-1:0];
			cy_q <= zero_q ? '0 : sy[COORD_W-1:0];
			np_q <= zero_q;
		end
	end

	assign out_valid = out_valid_q;
	assign center_x  = cx_q;
	assign center_y  = cy_q;
	assign no_points = np_q;

endmodule

[sv/thresholded_blob_centroid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thresholded blob centroid
// Centroid of above-threshold pixels of each frame, relative to the image center.
// ----------------------------------------------------------------------------
// Throughput: one pixel item per cycle while the two-entry record queue has room.
// Each frame record passes the back-end states MUL, DIFF, ABS, DIV and DONE in turn;
// DIV runs the one-bit-per-cycle shift-subtract divider, and DONE waits while the
// output register still holds an unaccepted item. The back end pops a new record
// only from IDLE, after it has loaded the result of the last one into the output.
// Reset: position, sums and count clear; registers return to 640 x 480, 200.
module thresholded_blob_centroid
	import tbc_pkg::*;
#(
	parameter int MAX_DIM     = 2048,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [PIX_W-1:0]            pixel_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [COORD_W-1:0]   center_x,
	output logic signed [COORD_W-1:0]   center_y,
	output logic                        no_points,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data
);

	localparam int POS_W = $clog2(MAX_DIM);
	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int CNT_W = $clog2(MAX_DIM * MAX_DIM + 1);
	localparam int SUM_W = CNT_W + POS_W;
	localparam int REC_W = 2 * SUM_W + CNT_W + 2 * DIM_W;
	localparam logic [31:0] MAX_DIM_U = 32'(MAX_DIM);

	logic [CFG_DIM_W-1:0] width_q;
	logic [CFG_DIM_W-1:0] height_q;
	logic [THR_W-1:0]     thr_q;
	logic [DIM_W-1:0]     w_eff;
	logic [DIM_W-1:0]     h_eff;

	logic             q_full;
	logic             q_valid;
	logic             push;
	logic             pop;
	logic [REC_W-1:0] rec_in;
	logic [REC_W-1:0] rec_out;
	logic [COORD_W-1:0] cx;
	logic [COORD_W-1:0] cy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			thr_q    <= THRESHOLD_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:      width_q  <= cfg_data;
				REG_FRAME_HEIGHT:     height_q <= cfg_data;
				REG_BRIGHT_THRESHOLD: thr_q    <= cfg_data[THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// A zero size counts as one; anything past MAX_DIM counts as MAX_DIM.
	assign w_eff = (width_q == '0) ? DIM_W'(1) :
		(32'(width_q) > MAX_DIM_U) ? DIM_W'(MAX_DIM) : DIM_W'(width_q);
	assign h_eff = (height_q == '0) ? DIM_W'(1) :
		(32'(height_q) > MAX_DIM_U) ? DIM_W'(MAX_DIM) : DIM_W'(height_q);

	tbc_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel_value (pixel_value),
		.frame_w     (w_eff),
		.frame_h     (h_eff),
		.threshold   (thr_q),
		.q_full      (q_full),
		.push        (push),
		.rec_data    (rec_in)
	);

	tbc_queue #(
		.WIDTH (REC_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (rec_in),
		.pop       (pop),
		.pop_data  (rec_out),
		.full      (q_full),
		.not_empty (q_valid)
	);

	tbc_back #(
		.MAX_DIM (MAX_DIM)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.rec_data  (rec_out),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.center_x  (cx),
		.center_y  (cy),
		.no_points (no_points)
	);

	assign center_x = signed'(cx);
	assign center_y = signed'(cy);

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !q_full)
		else $error("frame record pushed into a full queue");

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> q_valid)
		else $error("frame record popped from an empty queue");

	assert property (@(posedge clk) disable iff (!arst_n) push |=> q_valid)
		else $error("pushed frame record not visible to the back end");

	assert property (@(posedge clk) disable iff (!arst_n) q_full |-> q_valid)
		else $error("queue reports full while empty");

endmodule

[tb/sv/centroid_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centroid checker
// Watches the pixel, result and register channels of the centroid block,
// tracks frame position and first moments itself, and compares every result
// item field by field with the oldest predicted centroid.
// ----------------------------------------------------------------------------
module centroid_check
	import tbc_pkg::*;
#(
	parameter int MAX_DIM = 2048
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [PIX_W-1:0]          pixel_value,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic signed [COORD_W-1:0] center_x,
	input  logic signed [COORD_W-1:0] center_y,
	input  logic                      no_points,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	output int                        mismatches,
	output int                        centroids_due
);

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      empty_frame;
	} centroid_t;

	centroid_t expected_centroids[$];

	logic [CFG_DIM_W-1:0] width_reg;
	logic [CFG_DIM_W-1:0] height_reg;
	logic [THR_W-1:0]     thr_reg;

	logic [10:0] col_pos;
	logic [10:0] row_pos;
	logic [33:0] col_sum;
	logic [33:0] row_sum;
	logic [22:0] bright_cnt;

	int        err_count;
	centroid_t want;

	// Sizes out of range are used as the nearest legal one.
	function automatic logic [CFG_DIM_W-1:0] usable_dim(input logic [CFG_DIM_W-1:0] v);
		if (v == '0)
			return CFG_DIM_W'(1);
		if (v > MAX_DIM)
			return CFG_DIM_W'(MAX_DIM);
		return v;
	endfunction

	task automatic take_pixel(input logic [PIX_W-1:0] pix);
		logic [CFG_DIM_W-1:0] w;
		logic [CFG_DIM_W-1:0] h;
		longint               n;
		longint               nx;
		longint               ny;
		centroid_t            c;
		w = usable_dim(width_reg);
		h = usable_dim(height_reg);
		if (pix > thr_reg) begin
			col_sum    += 34'(col_pos);
			row_sum    += 34'(row_pos);
			bright_cnt += 23'd1;
		end
		// A position at or past the last column or row ends it, so a size
		// that shrinks mid-frame closes the row or frame on the next pixel.
		if ({1'b0, col_pos} + 12'd1 < w) begin
			col_pos += 11'd1;
			return;
		end
		col_pos = '0;
		if ({1'b0, row_pos} + 12'd1 < h) begin
			row_pos += 11'd1;
			return;
		end
		row_pos = '0;
		if (bright_cnt == '0) begin
			c = '{x: '0, y: '0, empty_frame: 1'b1};
		end else begin
			n  = longint'(bright_cnt);
			nx = 2 * longint'(col_sum) - n * longint'(w);
			ny = n * longint'(h) - 2 * longint'(row_sum);
			// Signed division truncates toward zero.
			nx = nx / (2 * n);
			ny = ny / (2 * n);
			c.x           = nx[COORD_W-1:0];
			c.y           = ny[COORD_W-1:0];
			c.empty_frame = 1'b0;
		end
		expected_centroids.push_back(c);
		col_sum    = '0;
		row_sum    = '0;
		bright_cnt = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg     = WIDTH_RST;
			height_reg    = HEIGHT_RST;
			thr_reg       = THRESHOLD_RST;
			col_pos       = '0;
			row_pos       = '0;
			col_sum       = '0;
			row_sum       = '0;
			bright_cnt    = '0;
			err_count     = 0;
			expected_centroids.delete();
			mismatches    <= 0;
			centroids_due <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_centroids.size() == 0) begin
					$error("centroid item with none expected: center_x %0d center_y %0d no_points %0b",
						center_x, center_y, no_points);
					err_count++;
				end else begin
					want = expected_centroids.pop_front();
					if (center_x !== want.x) begin
						$error("center_x expected %0d actual %0d", want.x, center_x);
						err_count++;
					end
					if (center_y !== want.y) begin
						$error("center_y expected %0d actual %0d", want.y, center_y);
						err_count++;
					end
					if (no_points !== want.empty_frame) begin
						$error("no_points expected %0b actual %0b", want.empty_frame, no_points);
						err_count++;
					end
				end
			end
			// A pixel taken at the same edge as a register write still sees
			// the old register value.
			if (in_valid && in_ready)
				take_pixel(pixel_value);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FRAME_WIDTH:      width_reg  = cfg_data[CFG_DIM_W-1:0];
					REG_FRAME_HEIGHT:     height_reg = cfg_data[CFG_DIM_W-1:0];
					REG_BRIGHT_THRESHOLD: thr_reg    = cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
			mismatches    <= err_count;
			centroids_due <= expected_centroids.size();
		end
	end

endmodule

[tb/sv/thresholded_blob_centroid_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centroid block testbench
// Drives pixel streams and register writes into the centroid block with
// random gaps on both sides: a directed opening, long one-row and one-column
// edge frames, then random frames of many sizes, thresholds and brightness
// patterns.
// ----------------------------------------------------------------------------
module thresholded_blob_centroid_tb;
	import tbc_pkg::*;

	localparam int MAX_DIM       = 2048;
	localparam int MAX_GAP       = 17;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_ITEMS  = 560;
	localparam int EDGE_DIM      = 128;
	// Well above the slowest legal run.
	localparam int LIMIT_CYCLES  = 400_000;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

	typedef enum int {
		PIX_UNIFORM,
		PIX_NEAR_THR,
		PIX_SPARSE,
		PIX_DARK
	} pix_mode_t;

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      in_valid    = 1'b0;
	logic                      in_ready;
	logic [PIX_W-1:0]          pixel_value = '0;
	logic                      out_valid;
	logic                      out_ready   = 1'b0;
	logic signed [COORD_W-1:0] center_x;
	logic signed [COORD_W-1:0] center_y;
	logic                      no_points;
	logic                      cfg_valid   = 1'b0;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index   = '0;
	logic [CFG_DATA_W-1:0]     cfg_data    = '0;

	int mismatches;
	int centroids_due;
	int cycle_count = 0;

	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;

	logic [CFG_DIM_W-1:0] cur_w   = WIDTH_RST;
	logic [CFG_DIM_W-1:0] cur_h   = HEIGHT_RST;
	logic [THR_W-1:0]     cur_thr = THRESHOLD_RST;

	thresholded_blob_centroid #(
		.MAX_DIM(MAX_DIM)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_value(pixel_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.center_x   (center_x),
		.center_y   (center_y),
		.no_points  (no_points),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	centroid_check #(
		.MAX_DIM(MAX_DIM)
	) u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_value  (pixel_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.center_x     (center_x),
		.center_y     (center_y),
		.no_points    (no_points),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.centroids_due(centroids_due)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Result side: a fresh stall is drawn for every result item.
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	function automatic int dim_of(input logic [CFG_DIM_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return int'(v);
	endfunction

	task automatic send_pixel(input logic [PIX_W-1:0] pix);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		pixel_value <= pix;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic stream_pixels(input int count, input pix_mode_t mode);
		int v;
		for (int i = 0; i < count; i++) begin
			case (mode)
				PIX_NEAR_THR: begin
					v = int'(cur_thr) + int'($urandom_range(0, 4)) - 2;
					if (v < 0)
						v = 0;
					if (v > 255)
						v = 255;
				end
				PIX_SPARSE: v = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 15);
				PIX_DARK:   v = 0;
				default:    v = $urandom_range(0, 255);
			endcase
			send_pixel(PIX_W'(v));
		end
	endtask

	// One bright pixel at a chosen place in an otherwise dark run.
	task automatic send_single_spot(input int count, input int hot);
		for (int i = 0; i < count; i++)
			send_pixel((i == hot) ? 8'd255 : 8'd0);
	endtask

	// Waits until every predicted centroid has come out and the back end has
	// had time to finish; register writes are only made after this.
	task automatic settle_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (centroids_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_FRAME_WIDTH:      cur_w   = data[CFG_DIM_W-1:0];
			REG_FRAME_HEIGHT:     cur_h   = data[CFG_DIM_W-1:0];
			REG_BRIGHT_THRESHOLD: cur_thr = data[THR_W-1:0];
			default: ;
		endcase
	endtask

	initial begin
		int         small_items;
		int         frame_px;
		int         count;
		pix_mode_t  mode;
		logic [7:0] thr;

		small_items = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Start a frame at the reset size, with the threshold boundary in it.
		send_pixel(8'd255);
		send_pixel(8'd201);
		send_pixel(8'd200);
		send_pixel(8'd0);
		// Shrinking to 1 x 1 mid-frame ends the frame on the next pixel.
		settle_block();
		write_reg(REG_FRAME_WIDTH, 12'd0);
		write_reg(REG_FRAME_HEIGHT, 12'd0);
		send_pixel(8'd0);
		// A negative half pixel must truncate to zero, not to minus one.
		send_pixel(8'd255);
		settle_block();
		write_reg(REG_BRIGHT_THRESHOLD, 12'd255);
		send_pixel(8'd255);
		settle_block();
		write_reg(REG_BRIGHT_THRESHOLD, 12'd0);
		send_pixel(8'd0);
		send_pixel(8'd1);
		settle_block();
		write_reg(REG_FRAME_WIDTH, 12'd3);
		write_reg(REG_FRAME_HEIGHT, 12'd2);
		write_reg(REG_BRIGHT_THRESHOLD, 12'd100);
		send_pixel(8'd101);
		send_pixel(8'd100);
		send_pixel(8'd0);
		send_pixel(8'd255);
		send_pixel(8'd0);
		send_pixel(8'd255);
		settle_block();
		write_reg(REG_FRAME_WIDTH, 12'd2);
		write_reg(REG_FRAME_HEIGHT, 12'd3);
		write_reg(CFG_IDX_SPARE, 12'hFFF);
		stream_pixels(6, PIX_UNIFORM);

		// Long one-row and one-column frames with the centroid at either end.
		settle_block();
		tx_idle_on = 1'b0;
		write_reg(REG_BRIGHT_THRESHOLD, 12'hFC8);
		write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(EDGE_DIM));
		write_reg(REG_FRAME_HEIGHT, 12'd1);
		send_single_spot(EDGE_DIM, EDGE_DIM - 1);
		send_single_spot(EDGE_DIM, 0);
		settle_block();
		write_reg(REG_FRAME_WIDTH, 12'd1);
		write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(EDGE_DIM));
		send_single_spot(EDGE_DIM, 0);
		send_single_spot(EDGE_DIM, EDGE_DIM - 1);

		while (small_items < RANDOM_ITEMS) begin
			settle_block();
			tx_idle_on = $urandom_range(0, 3) != 0;
			rx_idle_on = $urandom_range(0, 3) != 0;
			mode       = pix_mode_t'($urandom_range(0, 3));
			if (dim_of(cur_w) * dim_of(cur_h) > 36 || $urandom_range(0, 2) == 0)
				write_reg(REG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(0, 6)));
			if (dim_of(cur_w) * dim_of(cur_h) > 36 || $urandom_range(0, 2) == 0)
				write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(0, 6)));
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 3))
					0:       thr = 8'd0;
					1:       thr = 8'd255;
					default: thr = 8'($urandom_range(0, 255));
				endcase
				write_reg(REG_BRIGHT_THRESHOLD, {4'($urandom_range(0, 15)), thr});
			end
			if ($urandom_range(0, 7) == 0)
				write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom_range(0, 4095)));
			frame_px = dim_of(cur_w) * dim_of(cur_h);
			// Most phases are whole frames; the rest may break off mid-frame.
			if ($urandom_range(0, 3) == 0)
				count = $urandom_range(1, 2 * frame_px + 1);
			else
				count = frame_px * $urandom_range(1, 4);
			stream_pixels(count, mode);
			small_items += count;
		end

		settle_block();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
